FILE: rtl/llrc_pkg.sv
// ----------------------------------------------------------------------------
// llrc_pkg
// Shared widths, register indexes, item types and the sine table builder
// for the laser line row centroid block.
// ----------------------------------------------------------------------------
package llrc_pkg;

  localparam int COLOR_W     = 8;
  localparam int RGB_W       = COLOR_W + 2;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 10;
  localparam int ANGLE_W     = 9;
  localparam int SUM_W       = 20;
  localparam int COUNT_W     = 11;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 14;
  localparam int CENT_W      = COL_W;   // centroid never exceeds the widest column
  localparam int POINT_W     = 12;
  localparam int ANGLE_STEPS = 360;
  localparam int QUARTER     = 90;
  localparam int MAX_WIDTH   = 1024;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM    = 3'd5;

  // register reset values
  localparam logic [COLOR_W-1:0] THRESHOLD_RST = 8'd170;
  localparam logic [GAIN_W-1:0]  GAIN_RST      = 16'd17436;
  localparam logic [COL_W-1:0]   LEFT_RST      = 10'd0;
  localparam logic [COL_W-1:0]   RIGHT_RST     = 10'd1023;
  localparam logic [ROW_W-1:0]   TOP_RST       = 10'd0;
  localparam logic [ROW_W-1:0]   BOTTOM_RST    = 10'd1023;

  localparam int          Q30_SHIFT = 30;
  localparam logic [63:0] PI_Q30    = 64'd3373259426;

  typedef struct packed {
    logic [COLOR_W-1:0] threshold;
    logic [GAIN_W-1:0]  gain;
    logic [COL_W-1:0]   left;
    logic [COL_W-1:0]   right;
    logic [ROW_W-1:0]   top;
    logic [ROW_W-1:0]   bottom;
  } cfg_t;

  // one finished row, handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
    logic [ANGLE_W-1:0] angle;
    logic [ROW_W-1:0]   height;
  } job_t;

  // sin of d degrees (0..90) via Q30 Taylor series, rounded to frac bits.
  // Only evaluated on constants to build the table.
  function automatic longint quarter_sin(input int unsigned d, input int unsigned frac);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] u;
    longint      acc;
    x    = (64'(d) * PI_Q30) / 64'd180;
    x2   = (x * x) >> Q30_SHIFT;
    term = x;
    acc  = longint'(x);
    term = ((term * x2) >> Q30_SHIFT) / 64'd6;   acc = acc - longint'(term);
    term = ((term * x2) >> Q30_SHIFT) / 64'd20;  acc = acc + longint'(term);
    term = ((term * x2) >> Q30_SHIFT) / 64'd42;  acc = acc - longint'(term);
    term = ((term * x2) >> Q30_SHIFT) / 64'd72;  acc = acc + longint'(term);
    term = ((term * x2) >> Q30_SHIFT) / 64'd110; acc = acc - longint'(term);
    term = ((term * x2) >> Q30_SHIFT) / 64'd156; acc = acc + longint'(term);
    term = ((term * x2) >> Q30_SHIFT) / 64'd210; acc = acc - longint'(term);
    term = ((term * x2) >> Q30_SHIFT) / 64'd272; acc = acc + longint'(term);
    if (acc < 0) begin
      acc = 0;
    end
    u = 64'(acc) + (64'd1 << (Q30_SHIFT - frac - 1));
    return longint'(u >> (Q30_SHIFT - frac));
  endfunction

  // full circle by quadrant mirroring
  function automatic longint sin_deg(input int unsigned d, input int unsigned frac);
    longint s;
    if (d < QUARTER) begin
      s = quarter_sin(d, frac);
    end else if (d < 2 * QUARTER) begin
      s = quarter_sin(2 * QUARTER - d, frac);
    end else if (d < 3 * QUARTER) begin
      s = -quarter_sin(d - 2 * QUARTER, frac);
    end else begin
      s = -quarter_sin(4 * QUARTER - d, frac);
    end
    return s;
  endfunction

endpackage

FILE: rtl/laser_line_row_centroid_to_point.sv
// ----------------------------------------------------------------------------
// laser_line_row_centroid_to_point
// Laser line row centroid to turntable point: one point per lit frame row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one RGB pixel per transfer, tagged with its
//   column, row, turntable angle and a row_end flag on the last pixel of a
//   row. Pixels are taken one per cycle; in_stall rises only when four
//   finished rows are waiting for the point builder.
//   Result channel (out_*): one point (angle, x, height, z) per row that
//   had at least one lit pixel inside the crop window. Rows with none give
//   nothing. The result sits in an output register; while out_stall is high
//   it holds, and the front keeps taking pixels meanwhile.
//   Config channel (cfg_*): cfg_ready is always high; write only while idle.
//   Throughput: one pixel per cycle while in_stall is low. The point builder
//   takes a row from the queue only when idle and works it through the
//   bit-serial centroid divider before it can take the next one.
//   Reset (rst_n low, synchronous): sums and queue cleared, registers back
//   to their defaults, out_valid low.
// ----------------------------------------------------------------------------
module laser_line_row_centroid_to_point
  import llrc_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = 14
)
(
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [COLOR_W-1:0]           in_red,
  input  logic [COLOR_W-1:0]           in_green,
  input  logic [COLOR_W-1:0]           in_blue,
  input  logic [COL_W-1:0]             in_column,
  input  logic [ROW_W-1:0]             in_row,
  input  logic [ANGLE_W-1:0]           in_angle_deg,
  input  logic                         in_row_end,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ANGLE_W-1:0]           out_point_angle,
  output logic signed [POINT_W-1:0]    out_point_x,
  output logic [ROW_W-1:0]             out_point_height,
  output logic signed [POINT_W-1:0]    out_point_z,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  cfg_t cfg_r;
  logic in_accept;
  logic q_push;
  job_t q_push_job;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t q_head_job;

  // Register file: always ready, writes to unused indexes fall away.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= THRESHOLD_RST;
      cfg_r.gain      <= GAIN_RST;
      cfg_r.left      <= LEFT_RST;
      cfg_r.right     <= RIGHT_RST;
      cfg_r.top       <= TOP_RST;
      cfg_r.bottom    <= BOTTOM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD: cfg_r.threshold <= cfg_data[COLOR_W-1:0];
        REG_GAIN:      cfg_r.gain      <= cfg_data[GAIN_W-1:0];
        REG_LEFT:      cfg_r.left      <= cfg_data[COL_W-1:0];
        REG_RIGHT:     cfg_r.right     <= cfg_data[COL_W-1:0];
        REG_TOP:       cfg_r.top       <= cfg_data[ROW_W-1:0];
        REG_BOTTOM:    cfg_r.bottom    <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Backpressure only when the row queue is full; pixels otherwise
  // stream straight through the accumulator.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  // Front: classify pixels, accumulate lit columns, close rows.
  llrc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .red       (in_red),
    .green     (in_green),
    .blue      (in_blue),
    .column    (in_column),
    .row       (in_row),
    .angle_deg (in_angle_deg),
    .row_end   (in_row_end),
    .cfg       (cfg_r),
    .push      (q_push),
    .push_job  (q_push_job)
  );

  // Finished rows wait here so a stalled receiver does not stop the pixels.
  llrc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_job (q_head_job)
  );

  // Back: divide, scale by gain and trig, saturate, register the point.
  llrc_back #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_empty      (q_empty),
    .head_job     (q_head_job),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_angle  (out_point_angle),
    .point_x      (out_point_x),
    .point_height (out_point_height),
    .point_z      (out_point_z)
  );

endmodule

FILE: rtl/llrc_front.sv
// ----------------------------------------------------------------------------
// llrc_front
// Pixel classifier and row accumulator: thresholds each pixel inside the
// crop window, sums lit columns and counts them, hands finished rows on.
// ----------------------------------------------------------------------------
module llrc_front
  import llrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [COLOR_W-1:0] red,
  input  logic [COLOR_W-1:0] green,
  input  logic [COLOR_W-1:0] blue,
  input  logic [COL_W-1:0]   column,
  input  logic [ROW_W-1:0]   row,
  input  logic [ANGLE_W-1:0] angle_deg,
  input  logic               row_end,
  input  cfg_t               cfg,
  output logic               push,
  output job_t               push_job
);

  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_nxt;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;

  logic [RGB_W-1:0]   rgb_sum;
  logic [RGB_W-1:0]   lit_level;
  logic [COL_W-1:0]   rel;
  logic [SUM_W:0]     sum_add;
  logic               in_win;
  logic               take;
  logic [ANGLE_W-1:0] angle_red;

  // avg > thr  <=>  r+g+b > 3*thr + 2
  assign rgb_sum   = RGB_W'(red) + RGB_W'(green) + RGB_W'(blue);
  assign lit_level = RGB_W'({cfg.threshold, 1'b0}) + RGB_W'(cfg.threshold) + RGB_W'(2);

  assign in_win = (column >= cfg.left) && (column <= cfg.right) &&
                  (row >= cfg.top) && (row <= cfg.bottom);
  assign rel     = column - cfg.left;
  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(rel);

  assign take = in_win && (rgb_sum > lit_level) && (int'(rel) < MAX_WIDTH) &&
                (count_r != {COUNT_W{1'b1}}) && !sum_add[SUM_W];

  assign sum_nxt   = take ? sum_add[SUM_W-1:0] : sum_r;
  assign count_nxt = take ? count_r + COUNT_W'(1) : count_r;

  assign angle_red = (angle_deg >= ANGLE_W'(ANGLE_STEPS)) ?
                     angle_deg - ANGLE_W'(ANGLE_STEPS) : angle_deg;

  assign push            = accept && row_end && (count_nxt != '0);
  assign push_job.sum    = sum_nxt;
  assign push_job.count  = count_nxt;
  assign push_job.angle  = angle_red;
  assign push_job.height = row - cfg.top;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else if (accept) begin
      if (row_end) begin
        sum_r   <= '0;
        count_r <= '0;
      end else begin
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule

FILE: rtl/llrc_queue.sv
// ----------------------------------------------------------------------------
// llrc_queue
// Small FIFO of finished rows between the front and the back.
// ----------------------------------------------------------------------------
module llrc_queue
  import llrc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head_job
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full     = (count_r == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

FILE: rtl/llrc_back.sv
// ----------------------------------------------------------------------------
// llrc_back
// Point builder: bit-serial centroid divide, gain scaling, cos/sin scaling
// with truncation and saturation, and the output register.
// ----------------------------------------------------------------------------
module llrc_back
  import llrc_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = 14
)
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      q_empty,
  input  job_t                      head_job,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ANGLE_W-1:0]        point_angle,
  output logic signed [POINT_W-1:0] point_x,
  output logic [ROW_W-1:0]          point_height,
  output logic signed [POINT_W-1:0] point_z
);

  localparam int TW         = TRIG_FRAC_BITS + 2;
  localparam int TMAG_W     = TRIG_FRAC_BITS + 1;
  localparam int RAD_W      = CENT_W + GAIN_W;
  localparam int PROD_W     = RAD_W + TMAG_W;
  localparam int MAG_W      = RAD_W + 1 - GAIN_FRAC;
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int POS_LIM    = 2 ** (POINT_W - 1) - 1;
  localparam int NEG_LIM    = 2 ** (POINT_W - 1);

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_GAIN, ST_PROD, ST_EMIT} state_t;

  state_t                state_r;
  logic [SUM_W-1:0]      quo_r;
  logic [COUNT_W-1:0]    rem_r;
  logic [COUNT_W-1:0]    den_r;
  logic [STEP_W-1:0]     step_r;
  logic [ANGLE_W-1:0]    ang_r;
  logic [ROW_W-1:0]      height_r;
  logic [RAD_W-1:0]      radius_r;
  logic signed [TW-1:0]  sin_r;
  logic signed [TW-1:0]  cos_r;
  logic [MAG_W-1:0]      magx_r;
  logic [MAG_W-1:0]      magz_r;
  logic                  negx_r;
  logic                  negz_r;
  logic                  out_valid_r;

  logic signed [TW-1:0]  sin_rom [ANGLE_STEPS];
  logic [COUNT_W:0]      shifted;
  logic                  fits;
  logic [COUNT_W-1:0]    rem_nxt;
  logic [SUM_W-1:0]      quo_nxt;
  logic [ANGLE_W:0]      ang_plus;
  logic [ANGLE_W-1:0]    cos_idx;
  logic [TMAG_W-1:0]     cos_mag;
  logic [TMAG_W-1:0]     sin_mag;
  logic [PROD_W-1:0]     prod_x;
  logic [PROD_W-1:0]     prod_z;

  for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_rom
    assign sin_rom[g] = TW'(sin_deg(g, TRIG_FRAC_BITS));
  end

  function automatic logic signed [POINT_W-1:0] saturate(input logic [MAG_W-1:0] mag,
                                                          input logic neg);
    logic [MAG_W-1:0] lim;
    logic [MAG_W-1:0] m;
    lim = neg ? MAG_W'(NEG_LIM) : MAG_W'(POS_LIM);
    m   = (mag > lim) ? lim : mag;
    return neg ? -POINT_W'(m) : POINT_W'(m);
  endfunction

  // restoring divide, one quotient bit per cycle
  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};
  assign rem_nxt = fits ? COUNT_W'(shifted - {1'b0, den_r}) : shifted[COUNT_W-1:0];
  assign quo_nxt = {quo_r[SUM_W-2:0], fits};

  assign ang_plus = (ANGLE_W + 1)'(ang_r) + (ANGLE_W + 1)'(QUARTER);
  assign cos_idx  = (ang_plus >= (ANGLE_W + 1)'(ANGLE_STEPS)) ?
                    ANGLE_W'(ang_plus - (ANGLE_W + 1)'(ANGLE_STEPS)) : ANGLE_W'(ang_plus);

  assign cos_mag = cos_r[TW-1] ? TMAG_W'(-cos_r) : TMAG_W'(cos_r);
  assign sin_mag = sin_r[TW-1] ? TMAG_W'(-sin_r) : TMAG_W'(sin_r);
  assign prod_x  = PROD_W'(radius_r) * PROD_W'(cos_mag);
  assign prod_z  = PROD_W'(radius_r) * PROD_W'(sin_mag);

  assign pop       = (state_r == ST_IDLE) && !q_empty;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // in ST_EMIT a leaving point is replaced by the new one below
      if (out_valid_r && !out_stall && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            quo_r    <= head_job.sum;
            den_r    <= head_job.count;
            rem_r    <= '0;
            ang_r    <= head_job.angle;
            height_r <= head_job.height;
            step_r   <= '0;
            state_r  <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r  <= rem_nxt;
          quo_r  <= quo_nxt;
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(SUM_W - 1)) begin
            state_r <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          radius_r <= RAD_W'(quo_r[CENT_W-1:0]) * RAD_W'(cfg.gain);
          sin_r    <= sin_rom[ang_r];
          cos_r    <= sin_rom[cos_idx];
          state_r  <= ST_PROD;
        end
        ST_PROD: begin
          magx_r  <= prod_x[PROD_W-1 -: MAG_W];
          magz_r  <= prod_z[PROD_W-1 -: MAG_W];
          negx_r  <= cos_r[TW-1];
          negz_r  <= sin_r[TW-1];
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            point_angle  <= ang_r;
            point_x      <= saturate(magx_r, negx_r);
            point_height <= height_r;
            point_z      <= saturate(magz_r, negz_r);
            out_valid_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/llrc_checker.sv
// ----------------------------------------------------------------------------
// llrc_checker
// Port-level checks for the laser line row centroid block.
// ----------------------------------------------------------------------------
module llrc_checker
  import llrc_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [ANGLE_W-1:0]        out_point_angle,
  input logic signed [POINT_W-1:0] out_point_x,
  input logic [ROW_W-1:0]          out_point_height,
  input logic signed [POINT_W-1:0] out_point_z
);

  // reset empties the queue and the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear out_valid or in_stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_point_angle) && $stable(out_point_x) &&
                               $stable(out_point_height) && $stable(out_point_z))
    else $error("stalled result changed");

  // angle is reduced before the table lookup
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_point_angle < ANGLE_W'(ANGLE_STEPS))
    else $error("point angle out of range");

endmodule

bind laser_line_row_centroid_to_point llrc_checker u_checker (.*);

FILE: tb/llrc_point_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// llrc_point_checker
// Watches the pixel, point and config channels of the row centroid block.
// It keeps its own register copy and row sums, works out the point of each
// finished row and compares every point transfer against the oldest one.
// ----------------------------------------------------------------------------
module llrc_point_checker
  import llrc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [COLOR_W-1:0]        in_red,
  input  logic [COLOR_W-1:0]        in_green,
  input  logic [COLOR_W-1:0]        in_blue,
  input  logic [COL_W-1:0]          in_column,
  input  logic [ROW_W-1:0]          in_row,
  input  logic [ANGLE_W-1:0]        in_angle_deg,
  input  logic                      in_row_end,

  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [ANGLE_W-1:0]        out_point_angle,
  input  logic signed [POINT_W-1:0] out_point_x,
  input  logic [ROW_W-1:0]          out_point_height,
  input  logic signed [POINT_W-1:0] out_point_z,

  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,

  output int                        mismatches,
  output int                        points_pending
);

  localparam int          SINE_FRAC   = 14;
  localparam int unsigned SUM_LIMIT   = (1 << SUM_W) - 1;
  localparam int unsigned COUNT_LIMIT = (1 << COUNT_W) - 1;

  typedef struct packed {
    logic [ANGLE_W-1:0]        angle;
    logic signed [POINT_W-1:0] x;
    logic [ROW_W-1:0]          height;
    logic signed [POINT_W-1:0] z;
  } point_t;

  longint             sine_lut [ANGLE_STEPS];
  point_t             expected_points [$];

  logic [COLOR_W-1:0] threshold  = THRESHOLD_RST;
  logic [GAIN_W-1:0]  gain       = GAIN_RST;
  logic [COL_W-1:0]   win_left   = LEFT_RST;
  logic [COL_W-1:0]   win_right  = RIGHT_RST;
  logic [ROW_W-1:0]   win_top    = TOP_RST;
  logic [ROW_W-1:0]   win_bottom = BOTTOM_RST;
  int unsigned        col_sum    = 0;
  int unsigned        lit_cnt    = 0;
  int                 err_count  = 0;

  // first quadrant sine, Q30 Taylor series, rounded half up to SINE_FRAC bits
  function automatic longint quadrant_sine(input int unsigned deg);
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] t;
    longint      acc;
    int          k;
    ang  = (64'(deg) * PI_Q30) / 64'd180;
    ang2 = (ang * ang) >> Q30_SHIFT;
    t    = ang;
    acc  = longint'(ang);
    for (k = 1; k <= 8; k++) begin
      t = ((t * ang2) >> Q30_SHIFT) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(t);
      end else begin
        acc = acc + longint'(t);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return longint'((64'(acc) + (64'd1 << (Q30_SHIFT - SINE_FRAC - 1)))
                    >> (Q30_SHIFT - SINE_FRAC));
  endfunction

  // radius (Q.14) times trig (Q1.14), truncated toward zero, clamped to 12 bits
  function automatic logic signed [POINT_W-1:0] scale_axis(input longint unsigned radius,
                                                           input longint trig);
    longint unsigned mag;
    longint          v;
    mag = radius * longint'((trig < 0) ? -trig : trig);
    mag = mag >> (GAIN_FRAC + SINE_FRAC);
    if (mag > 4096) begin
      mag = 4096;
    end
    v = longint'(mag);
    if (trig < 0) begin
      v = -v;
    end
    if (v > 2047) begin
      v = 2047;
    end
    if (v < -2048) begin
      v = -2048;
    end
    return v[POINT_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] point mismatch: %s", $time, msg);
  endtask

  // row accumulation; on row end, queue the point if anything was lit
  task automatic accumulate_pixel(input logic [COLOR_W-1:0] r, g, b,
                                  input logic [COL_W-1:0] c,
                                  input logic [ROW_W-1:0] rw,
                                  input logic [ANGLE_W-1:0] a,
                                  input logic last);
    logic [ANGLE_W-1:0] ang;
    int unsigned        rel;
    int unsigned        avg;
    longint unsigned    radius;
    point_t             p;
    ang = (a >= ANGLE_STEPS) ? ANGLE_W'(a - ANGLE_STEPS) : a;
    if (c >= win_left && c <= win_right && rw >= win_top && rw <= win_bottom) begin
      rel = int'(c) - int'(win_left);
      avg = (int'(r) + int'(g) + int'(b)) / 3;
      if (avg > threshold && rel < MAX_WIDTH && lit_cnt < COUNT_LIMIT &&
          col_sum + rel <= SUM_LIMIT) begin
        col_sum += rel;
        lit_cnt += 1;
      end
    end
    if (last) begin
      if (lit_cnt != 0) begin
        radius   = longint'(col_sum / lit_cnt) * longint'(gain);
        p.angle  = ang;
        p.x      = scale_axis(radius, sine_lut[(int'(ang) + 90) % ANGLE_STEPS]);
        p.height = rw - win_top;
        p.z      = scale_axis(radius, sine_lut[ang]);
        expected_points = {expected_points, p};
      end
      col_sum = 0;
      lit_cnt = 0;
    end
  endtask

  initial begin : build_sine
    int unsigned d;
    int unsigned q;
    int unsigned rem;
    longint      s;
    for (d = 0; d < ANGLE_STEPS; d++) begin
      q   = d / 90;
      rem = d % 90;
      s   = (q % 2 == 1) ? quadrant_sine(90 - rem) : quadrant_sine(rem);
      sine_lut[d] = (q >= 2) ? -s : s;
    end
  end

  always @(posedge clk) begin : monitor
    point_t want;
    if (!rst_n) begin
      expected_points.delete();
      threshold  = THRESHOLD_RST;
      gain       = GAIN_RST;
      win_left   = LEFT_RST;
      win_right  = RIGHT_RST;
      win_top    = TOP_RST;
      win_bottom = BOTTOM_RST;
      col_sum    = 0;
      lit_cnt    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("unexpected point angle %0d x %0d height %0d z %0d",
                                    out_point_angle, out_point_x, out_point_height,
                                    out_point_z));
        end else begin
          want = expected_points.pop_front();
          if (out_point_angle !== want.angle)
            report_mismatch($sformatf("point_angle got %0d want %0d",
                                      out_point_angle, want.angle));
          if (out_point_x !== want.x)
            report_mismatch($sformatf("point_x got %0d want %0d",
                                      out_point_x, $signed(want.x)));
          if (out_point_height !== want.height)
            report_mismatch($sformatf("point_height got %0d want %0d",
                                      out_point_height, want.height));
          if (out_point_z !== want.z)
            report_mismatch($sformatf("point_z got %0d want %0d",
                                      out_point_z, $signed(want.z)));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD: threshold  = cfg_data[COLOR_W-1:0];
          REG_GAIN:      gain       = cfg_data[GAIN_W-1:0];
          REG_LEFT:      win_left   = cfg_data[COL_W-1:0];
          REG_RIGHT:     win_right  = cfg_data[COL_W-1:0];
          REG_TOP:       win_top    = cfg_data[ROW_W-1:0];
          REG_BOTTOM:    win_bottom = cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        accumulate_pixel(in_red, in_green, in_blue, in_column, in_row, in_angle_deg,
                         in_row_end);
      end
    end
    mismatches     <= err_count;
    points_pending <= expected_points.size();
  end

endmodule

FILE: tb/laser_line_row_centroid_to_point_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// laser_line_row_centroid_to_point_tb
// Drives pixel rows, config writes and output back-pressure into the row
// centroid block. A directed pass hits thresholds, angles, windows, gain
// saturation and accumulator limits; random phases follow under changing
// register settings. The checker instance does all prediction.
// ----------------------------------------------------------------------------
module laser_line_row_centroid_to_point_tb;
  import llrc_pkg::*;

  localparam int ITEM_TARGET   = 1250;
  localparam int RANDOM_PHASES = 10;
  // time for four queued rows and the last point to leave the builder, with margin
  localparam int DRAIN_CYCLES  = 150;
  localparam int CYCLE_LIMIT   = 400000;

  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;

  logic                      in_valid     = 1'b0;
  logic [COLOR_W-1:0]        in_red       = '0;
  logic [COLOR_W-1:0]        in_green     = '0;
  logic [COLOR_W-1:0]        in_blue      = '0;
  logic [COL_W-1:0]          in_column    = '0;
  logic [ROW_W-1:0]          in_row       = '0;
  logic [ANGLE_W-1:0]        in_angle_deg = '0;
  logic                      in_row_end   = 1'b0;
  logic                      in_stall;

  logic                      out_stall    = 1'b0;
  logic                      out_valid;
  logic [ANGLE_W-1:0]        out_point_angle;
  logic signed [POINT_W-1:0] out_point_x;
  logic [ROW_W-1:0]          out_point_height;
  logic signed [POINT_W-1:0] out_point_z;

  logic                      cfg_valid    = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index    = '0;
  logic [CFG_DATA_W-1:0]     cfg_data     = '0;
  logic                      cfg_ready;

  int                        mismatches;
  int                        points_pending;

  // quiet: no idling on either side (final phase)
  bit                        quiet        = 1'b0;
  // per-row choice of whether the sender inserts gaps
  bit                        row_gaps     = 1'b0;
  int                        cycle_count  = 0;
  int                        items_sent   = 0;
  int                        stall_run    = 0;

  // current register view, used only to shape stimulus
  logic [COLOR_W-1:0]        cur_thr      = THRESHOLD_RST;
  logic [COL_W-1:0]          cur_left     = LEFT_RST;
  logic [COL_W-1:0]          cur_right    = RIGHT_RST;
  logic [ROW_W-1:0]          cur_top      = TOP_RST;
  logic [ROW_W-1:0]          cur_bottom   = BOTTOM_RST;

  laser_line_row_centroid_to_point uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_angle_deg     (in_angle_deg),
    .in_row_end       (in_row_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_angle  (out_point_angle),
    .out_point_x      (out_point_x),
    .out_point_height (out_point_height),
    .out_point_z      (out_point_z),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  llrc_point_checker point_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_angle_deg     (in_angle_deg),
    .in_row_end       (in_row_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_angle  (out_point_angle),
    .out_point_x      (out_point_x),
    .out_point_height (out_point_height),
    .out_point_z      (out_point_z),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .points_pending   (points_pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver back-pressure: alternating runs of stall and free flow, so stalls
  // land on every phase of the builder.
  always @(posedge clk) begin : stall_gen
    bit hold;
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run == 0) begin
      hold = !out_stall && ($urandom_range(0, 2) == 0);
      out_stall <= hold;
      stall_run <= hold ? $urandom_range(0, 11) : $urandom_range(0, 39);
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  // One pixel transfer. Valid stays up into the next call unless a gap is
  // taken, so valid is never dropped and raised in the same step.
  task automatic push_pixel(input logic [COLOR_W-1:0] r, g, b,
                            input logic [COL_W-1:0] c,
                            input logic [ROW_W-1:0] rw,
                            input logic [ANGLE_W-1:0] a,
                            input logic last);
    in_valid     <= 1'b1;
    in_red       <= r;
    in_green     <= g;
    in_blue      <= b;
    in_column    <= c;
    in_row       <= rw;
    in_angle_deg <= a;
    in_row_end   <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (row_gaps && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // register write; valid drops for a cycle after each transfer
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int thr, gain, left, right, top, bottom);
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_GAIN,      CFG_DATA_W'(gain));
    write_reg(REG_LEFT,      CFG_DATA_W'(left));
    write_reg(REG_RIGHT,     CFG_DATA_W'(right));
    write_reg(REG_TOP,       CFG_DATA_W'(top));
    write_reg(REG_BOTTOM,    CFG_DATA_W'(bottom));
    cur_thr    = COLOR_W'(thr);
    cur_left   = COL_W'(left);
    cur_right  = COL_W'(right);
    cur_top    = ROW_W'(top);
    cur_bottom = ROW_W'(bottom);
  endtask

  // Idle point: stop sending, let every expected point drain, then wait out
  // the DRAIN_CYCLES margin before going on.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (points_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_between(input int lo, input int hi);
    if (lo <= hi) begin
      return $urandom_range(hi, lo);
    end
    return $urandom_range(1023, 0);
  endfunction

  // Pixel color: clearly above or below the threshold, sometimes right at
  // the truncated-average boundary, sometimes anything.
  task automatic make_color(input bit bright, output logic [COLOR_W-1:0] r, g, b);
    int th;
    int pick;
    int e;
    th   = cur_thr;
    pick = $urandom_range(0, 9);
    e    = th + $urandom_range(0, 3);
    if (pick == 0) begin
      {r, g, b} = 24'($urandom);
    end else if (pick == 1) begin
      r = COLOR_W'(th);
      g = COLOR_W'(th);
      b = COLOR_W'((e > 255) ? 255 : e);
    end else if (bright && th < 255) begin
      r = COLOR_W'($urandom_range(255, th + 1));
      g = COLOR_W'($urandom_range(255, th + 1));
      b = COLOR_W'($urandom_range(255, th + 1));
    end else if (!bright) begin
      r = COLOR_W'($urandom_range(th, 0));
      g = COLOR_W'($urandom_range(th, 0));
      b = COLOR_W'($urandom_range(th, 0));
    end else begin
      {r, g, b} = 24'($urandom);
    end
  endtask

  // A scan row: pixels clustered around a laser column inside the window,
  // plus strays; occasionally the row end is left off so sums carry over.
  task automatic random_row();
    int                 n;
    int                 rw;
    int                 center;
    int                 lo;
    int                 hi;
    int                 c;
    int                 i;
    logic [ANGLE_W-1:0] a;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
    bit                 drop_end;
    bit                 bright;
    n  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
    rw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                     : pick_between(cur_top, cur_bottom);
    a  = ($urandom_range(0, 9) == 0) ? ANGLE_W'($urandom_range(360, 511))
                                     : ANGLE_W'($urandom_range(0, 359));
    center   = pick_between(cur_left, cur_right);
    drop_end = ($urandom_range(0, 14) == 0);
    row_gaps = $urandom_range(0, 1);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        lo     = (center - 4 < int'(cur_left)) ? int'(cur_left) : center - 4;
        hi     = (center + 4 > cur_right) ? cur_right : center + 4;
        c      = pick_between(lo, hi);
        bright = ($urandom_range(0, 4) != 0);
      end else begin
        c      = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                             : pick_between(cur_left, cur_right);
        bright = ($urandom_range(0, 4) == 0);
      end
      make_color(bright, r, g, b);
      push_pixel(r, g, b, COL_W'(c), ROW_W'(rw), a, (i == n - 1) && !drop_end);
    end
  endtask

  // fully random pixel, row end one time in four
  task automatic noise_pixel();
    row_gaps = $urandom_range(0, 1);
    push_pixel(COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
               COL_W'($urandom), ROW_W'($urandom), ANGLE_W'($urandom),
               $urandom_range(0, 3) == 0);
  endtask

  task automatic run_directed();
    row_gaps = 1'b0;
    // reset registers: full window, threshold 170
    push_pixel(255, 255, 255,    0,    0,   0, 1);   // centroid zero
    push_pixel(171, 171, 171, 1023, 1023, 359, 1);   // just above threshold, far corner
    push_pixel(170, 170, 170,  500,    5,  90, 1);   // at threshold: nothing lit
    push_pixel(255, 255,   2,  100,    6,  90, 0);   // truncated average 170: dark
    push_pixel(255, 255,   3,  200,    6, 180, 0);   // truncated average 171: lit
    push_pixel(  0,   0,   0,  300,    6, 180, 1);
    push_pixel(255, 255, 255,  700,    7, 270, 1);
    push_pixel(200, 200, 200,   40,    8, 360, 1);   // angle wraps to 0
    push_pixel(200, 200, 200,   41,    9, 511, 1);   // angle wraps to 151
    push_pixel(200, 200, 200,   42,    9, 450, 1);
    // missing row end: sums carry into row 11
    push_pixel(255, 255, 255,  100,   10,  45, 0);
    push_pixel(255, 255, 255,  300,   11,  45, 1);

    // max gain, zero threshold: x saturates; row end above the window
    settle();
    set_config(0, 65535, 0, 1023, 500, 1023);
    push_pixel(255, 255, 255, 1023,  600, 180, 0);
    push_pixel(  0,   0,   0,    0,   10, 180, 1);
    push_pixel(255, 255, 255, 1023,  600,   0, 1);
    push_pixel(  1,   1,   1,  512,  700,  45, 1);

    // empty window
    settle();
    set_config(170, 17436, 600, 500, 0, 1023);
    push_pixel(255, 255, 255,  550,    3,  10, 1);

    // threshold at maximum: never lit
    settle();
    set_config(255, 17436, 0, 1023, 0, 1023);
    push_pixel(255, 255, 255,   10,    3,  10, 1);
  endtask

  // one long row that runs the column sum into its limit: 1025 far pixels
  // fill it exactly, the rest must not move it
  task automatic run_accumulator_limits();
    int i;
    settle();
    set_config(0, 17436, 0, 1023, 0, 1023);
    row_gaps = 1'b0;
    for (i = 0; i < 1030; i++) begin
      push_pixel(255, 255, 255, 1023, 20, 30, i == 1029);
    end
  endtask

  initial begin : stimulus
    int ph;
    int target;
    int start;
    int thr;
    int gain;
    int l;
    int r;
    int t;
    int bt;
    int tmp;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_accumulator_limits();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      // share what is left of the item budget over the remaining phases
      target = (ITEM_TARGET - items_sent) / (RANDOM_PHASES - ph);
      thr    = $urandom_range(0, 254);
      gain   = $urandom_range(0, 65535);
      l      = $urandom_range(0, 1023);
      r      = $urandom_range(0, 1023);
      t      = $urandom_range(0, 1023);
      bt     = $urandom_range(0, 1023);
      // mostly well-formed windows, now and then an inverted one
      if ($urandom_range(0, 6) != 0 && l > r) begin
        tmp = l; l = r; r = tmp;
      end
      if ($urandom_range(0, 6) != 0 && t > bt) begin
        tmp = t; t = bt; bt = tmp;
      end
      case (ph)
        0: set_config(170, 17436, 0, 1023, 0, 1023);
        1: set_config(0, 65535, 0, 1023, 0, 1023);
        2: begin
          // all-max window corner and threshold, zero gain: nothing lit
          set_config(255, 0, 1023, 1023, 1023, 1023);
          target = 40;
        end
        3: set_config(thr, gain, l, l, t, t);          // one-pixel window
        4: begin
          set_config(thr, gain, 700, 300, 0, 1023);     // inverted window
          target = 40;
        end
        default: set_config(thr, gain, l, r, t, bt);
      endcase
      // final phase runs flat out on both sides
      if (ph == RANDOM_PHASES - 1) begin
        quiet <= 1'b1;
      end
      start = items_sent;
      while (items_sent - start < target) begin
        if ($urandom_range(0, 6) == 0) begin
          noise_pixel();
        end else begin
          random_row();
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
